@@ rtl/pbskl_pkg.sv @@
`timescale 1ns / 1ps
package pbskl_pkg;
    localparam int BID_W = 6;
    localparam int CNT_W = 6;
    localparam int OUT_KEY_W = 32;
    localparam int IN_KEY_W = 32;

    localparam logic MODE_ENROLL = 1'b0;
    localparam logic MODE_LIST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENR_META,
        ST_ENR_RD,
        ST_ENR_CMP,
        ST_ENR_PUT,
        ST_LST_META,
        ST_LST_HDR,
        ST_LST_RD,
        ST_LST_WAIT,
        ST_LST_KEY
    } state_t;

    typedef struct packed {
        logic load;
        logic meta_rd;
        logic rd_shift;
        logic shift_wr;
        logic ins_wr;
        logic ovf_set;
        logic lst_rd;
        logic out_hdr;
        logic out_key;
    } cmd_t;

    typedef struct packed {
        logic is_list;
        logic in_range;
        logic full;
        logic pos_zero;
        logic prev_gt;
        logic cnt_zero;
        logic idx_last;
        logic out_busy;
        logic clr_busy;
    } sts_t;
endpackage

@@ rtl/per_bucket_sorted_key_lists_unit.sv @@
`timescale 1ns / 1ps
// Enroll: a key for a full bucket is dropped and sets its overflow flag, a key for a bucket
//   out of range is ignored; else up to BUCKET_DEPTH - 1 larger keys shift up and the key goes in.
// List: header first, then each key through the read, wait and key states; stalls hold it.
// One transaction at a time; no result for enroll.
// Reset clears counts and overflow flags in a pass over all BUCKETS after release,
//   input held off meanwhile; key memory is not cleared.
module per_bucket_sorted_key_lists_unit
    import pbskl_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int BUCKET_DEPTH = 32,
    parameter int KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode, name_key, bucket_id, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // is_header, bucket_id_res, entry_count, overflowed, key_out
    output logic        m_tlast
);
    cmd_t cmd;
    sts_t sts;
    logic [45:0] odata;

    pbskl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_tvalid), .s_ready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    pbskl_dp #(.BUCKETS(BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_data(s_tdata[38:0]), .cmd(cmd), .sts(sts),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(odata), .m_tlast(m_tlast)
    );

    assign m_tdata = {2'b00, odata};
endmodule

@@ rtl/pbskl_ctrl.sv @@
`timescale 1ns / 1ps
module pbskl_ctrl
    import pbskl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !sts.clr_busy;
                if (s_valid && !sts.clr_busy) begin
                    cmd.load = 1'b1;
                    state_next = ST_ENR_META;
                end
            end
            ST_ENR_META: begin
                cmd.meta_rd = 1'b1;
                state_next = sts.is_list ? ST_LST_META : ST_ENR_RD;
            end
            ST_ENR_RD: begin
                if (!sts.in_range) begin
                    state_next = ST_IDLE;
                end else if (sts.full) begin
                    cmd.ovf_set = 1'b1;
                    state_next = ST_IDLE;
                end else if (sts.pos_zero) begin
                    state_next = ST_ENR_PUT;
                end else begin
                    cmd.rd_shift = 1'b1;
                    state_next = ST_ENR_CMP;
                end
            end
            ST_ENR_CMP: begin
                if (sts.prev_gt) begin
                    cmd.shift_wr = 1'b1;
                    state_next = ST_ENR_RD;
                end else begin
                    state_next = ST_ENR_PUT;
                end
            end
            ST_ENR_PUT: begin
                cmd.ins_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LST_META: begin
                state_next = ST_LST_HDR;
            end
            ST_LST_HDR: begin
                if (!sts.out_busy) begin
                    cmd.out_hdr = 1'b1;
                    state_next = sts.cnt_zero ? ST_IDLE : ST_LST_RD;
                end
            end
            ST_LST_RD: begin
                cmd.lst_rd = 1'b1;
                state_next = ST_LST_WAIT;
            end
            ST_LST_WAIT: begin
                state_next = ST_LST_KEY;
            end
            ST_LST_KEY: begin
                if (!sts.out_busy) begin
                    cmd.out_key = 1'b1;
                    state_next = sts.idx_last ? ST_IDLE : ST_LST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.shift_wr && cmd.ins_wr)) else $error("two writes");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.out_hdr && cmd.out_key)) else $error("two outputs");
    a_put_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_wr |=> state_reg == ST_IDLE) else $error("put not final");
endmodule

@@ rtl/pbskl_dp.sv @@
`timescale 1ns / 1ps
module pbskl_dp
    import pbskl_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int BUCKET_DEPTH = 32,
    parameter int KEY_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_KEY_W+BID_W:0] in_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_KEY_W+BID_W+CNT_W+1:0] m_tdata,
    output logic                  m_tlast
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CW = $clog2(BUCKET_DEPTH + 1);

    logic [CW:0] meta_mem [BUCKETS];
    logic [KEY_BITS-1:0] key_mem [BUCKETS * (2 ** DW)];

    logic clr_busy_reg;
    logic [BW-1:0] clr_idx_reg;
    logic mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [BID_W-1:0] bid_reg;
    logic [CW-1:0] cnt_reg, pos_reg, idx_reg;
    logic ovf_b_reg;
    logic [KEY_BITS-1:0] rd_reg;
    logic obusy_reg;
    logic [OUT_KEY_W+BID_W+CNT_W+1:0] odata_reg;
    logic olast_reg;

    logic in_rng;
    logic [BW-1:0] bsel;
    logic [DW-1:0] wr_off, rd_off;
    logic [KEY_BITS-1:0] in_key;
    logic [OUT_KEY_W-1:0] key32;
    logic [CNT_W-1:0] cnt6;

    assign in_rng = ({26'd0, bid_reg} < 32'(BUCKETS));
    assign bsel = BW'(bid_reg);
    assign in_key = KEY_BITS'({32'd0, in_data[IN_KEY_W:1]});
    assign rd_off = cmd.rd_shift ? DW'(pos_reg - CW'(1)) : DW'(idx_reg);
    assign wr_off = DW'(pos_reg);
    assign key32 = OUT_KEY_W'({32'd0, rd_reg});
    assign cnt6 = CNT_W'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_data[0];
            key_reg <= in_key;
            bid_reg <= in_data[IN_KEY_W+BID_W:IN_KEY_W+1];
        end
        if (cmd.meta_rd) begin
            cnt_reg <= in_rng ? meta_mem[bsel][CW-1:0] : '0;
            pos_reg <= in_rng ? meta_mem[bsel][CW-1:0] : '0;
            ovf_b_reg <= in_rng ? meta_mem[bsel][CW] : 1'b0;
            idx_reg <= '0;
        end
        if (cmd.rd_shift || cmd.lst_rd) begin
            rd_reg <= key_mem[{bsel, rd_off}];
        end
        if (cmd.shift_wr) begin
            key_mem[{bsel, wr_off}] <= rd_reg;
            pos_reg <= pos_reg - CW'(1);
        end
        if (cmd.ins_wr) begin
            key_mem[{bsel, wr_off}] <= key_reg;
        end
        if (cmd.lst_rd) begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    // Walk every bucket once after reset to clear count and overflow flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + BW'(1);
            if (clr_idx_reg == BW'(BUCKETS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            meta_mem[clr_idx_reg] <= '0;
        end else if (cmd.ovf_set) begin
            meta_mem[bsel] <= {1'b1, cnt_reg};
        end else if (cmd.ins_wr) begin
            meta_mem[bsel] <= {ovf_b_reg, cnt_reg + CW'(1)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obusy_reg <= 1'b0;
        end else if (cmd.out_hdr || cmd.out_key) begin
            obusy_reg <= 1'b1;
        end else if (m_tready) begin
            obusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_hdr) begin
            odata_reg <= {{OUT_KEY_W{1'b0}}, ovf_b_reg, cnt6, bid_reg, 1'b1};
            olast_reg <= (cnt_reg == '0);
        end
        if (cmd.out_key) begin
            odata_reg <= {key32, ovf_b_reg, cnt6, bid_reg, 1'b0};
            olast_reg <= (idx_reg == cnt_reg);
        end
    end

    assign m_tvalid = obusy_reg;
    assign m_tdata = odata_reg;
    assign m_tlast = olast_reg;

    always_comb begin
        sts.is_list = (mode_reg == MODE_LIST);
        sts.in_range = in_rng;
        sts.full = (cnt_reg >= CW'(BUCKET_DEPTH));
        sts.pos_zero = (pos_reg == '0);
        sts.prev_gt = (rd_reg > key_reg);
        sts.cnt_zero = (cnt_reg == '0);
        sts.idx_last = (idx_reg == cnt_reg);
        sts.out_busy = obusy_reg && !m_tready;
        sts.clr_busy = clr_busy_reg;
    end

    a_pos_le: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_wr |-> pos_reg != '0) else $error("shift below zero");
    a_cnt_le: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_wr |-> cnt_reg < CW'(BUCKET_DEPTH)) else $error("insert full");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("output dropped");
endmodule
